>>> rtl/iee_pkg.sv
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_MUL   = 8'h2a;
    localparam logic [7:0] CH_DIV   = 8'h2f;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_BADCHAR   = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic       load_char;
        logic       push_val;
        logic       push_op;
        logic       pop_op;
        logic       rd_vals;
        logic       alu_start;
        logic       write_res;
        logic       flag_ovf;
        logic       flag_mal;
        logic       flag_bad;
        logic       finish;
        logic       clear;
    } iee_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       is_digit;
        logic       is_op;
        logic       last;
        logic       op_empty;
        logic       op_full;
        logic       val_full;
        logic       val_lt2;
        logic       top_ge;
        logic       alu_done;
    } iee_sts_t;

endpackage

>>> rtl/iee_if.sv
interface iee_in_if;
    import iee_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;
    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface iee_out_if;
    import iee_pkg::*;
    logic              valid;
    logic              ready;
    logic signed [31:0] value;
    logic [2:0]        status;
    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

>>> rtl/infix_expression_evaluator.sv
// Infix evaluator: one ASCII character per transfer on in_ch (digits and + - * /),
// one result on out_ch after the character marked last. A digit is pushed; an operator
// first reduces the stacked operators of equal or higher rank, then is pushed; a / with a
// nonzero divisor runs on the bit-per-cycle divider. A character is taken only once the
// one before it is done. The last character reduces what remains and waits while the previous result is
// still held on out_ch. Stacks are RAMs of STACK_DEPTH entries with registered read;
// errors are sticky within one expression.
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    iee_in_if.sink   in_ch,
    iee_out_if.source out_ch
);
    import iee_pkg::*;

    iee_cmd_t    cmd;
    iee_sts_t    sts;
    logic [31:0] value;

    iee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .char_code (in_ch.char_code),
        .last      (in_ch.last),
        .value     (value),
        .status    (out_ch.status)
    );

    assign out_ch.value = value;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alu_start |=> !in_ch.ready)
        else $error("input taken during reduction");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.status <= 3'd4)
        else $error("bad status code");
    a_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push_val && cmd.write_res))
        else $error("value stack double write");
endmodule

>>> rtl/iee_ram.sv
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/iee_alu.sv
module iee_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  iee_pkg::op_t       op,
    input  logic [31:0]        lhs,
    input  logic [31:0]        rhs,
    output logic               done,
    output logic [31:0]        res,
    output logic               div_zero
);
    import iee_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic        dz_reg, dz_next;
    logic [31:0] mag_a, mag_b;
    logic [32:0] trial;
    logic [31:0] prod;

    assign mag_a = lhs[31] ? (32'd0 - lhs) : lhs;
    assign mag_b = rhs[31] ? (32'd0 - rhs) : rhs;
    assign prod  = lhs * rhs;
    assign trial = {rem_reg[31:0], quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        dz_next   = dz_reg;
        if (start)
        begin
            dz_next = 1'b0;
            case (op)
                OP_ADD:
                begin
                    res_next  = lhs + rhs;
                    done_next = 1'b1;
                end
                OP_SUB:
                begin
                    res_next  = lhs - rhs;
                    done_next = 1'b1;
                end
                OP_MUL:
                begin
                    res_next  = prod;
                    done_next = 1'b1;
                end
                default:
                begin
                    if (mag_b == 32'd0)
                    begin
                        res_next  = 32'd0;
                        dz_next   = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        cnt_next  = 6'd32;
                        quo_next  = mag_a;
                        rem_next  = 33'd0;
                        dvs_next  = mag_b;
                        neg_next  = lhs[31] ^ rhs[31];
                    end
                end
            endcase
        end
        else if (busy_reg)
        begin
            // restoring division, one quotient bit per cycle
            if (trial[32])
            begin
                rem_next = {rem_reg[31:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (32'd0 - quo_next) : quo_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        dz_reg  <= dz_next;
    end

    assign done     = done_reg;
    assign res      = res_reg;
    assign div_zero = dz_reg;
endmodule

>>> rtl/iee_datapath.sv
module iee_datapath #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  iee_pkg::iee_cmd_t cmd,
    output iee_pkg::iee_sts_t sts,
    input  logic [7:0]        char_code,
    input  logic              last,
    output logic [31:0]       value,
    output logic [2:0]        status
);
    import iee_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]  char_reg;
    logic        last_reg;
    logic [CW-1:0] vcnt_reg, vcnt_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;
    logic [2:0]  err_reg, err_next;
    logic [31:0] value_reg;
    logic [2:0]  status_reg;
    op_t         cur_op;
    logic        is_digit, is_op;
    op_t         top_op;
    logic        alu_done, alu_dz;
    logic [31:0] alu_res;
    logic [31:0] rhs_reg;

    logic          vwe;
    logic [AW-1:0] vwaddr, vraddr;
    logic [31:0]   vwdata, vrdata;
    logic          owe;
    logic [AW-1:0] owaddr, oraddr;
    logic [1:0]    ordata;
    logic          rd_phase_reg;

    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_op = (char_reg == CH_PLUS) || (char_reg == CH_MINUS) ||
                   (char_reg == CH_MUL) || (char_reg == CH_DIV);

    always_comb
    begin
        case (char_reg)
            CH_PLUS:  cur_op = OP_ADD;
            CH_MINUS: cur_op = OP_SUB;
            CH_MUL:   cur_op = OP_MUL;
            default:  cur_op = OP_DIV;
        endcase
    end

    assign top_op = op_t'(ordata);

    // value stack: write push/result, read top then top-1
    always_comb
    begin
        vwe    = 1'b0;
        vwaddr = vcnt_reg[AW-1:0];
        vwdata = {24'd0, char_reg - CH_ZERO};
        if (cmd.push_val)
        begin
            vwe = 1'b1;
        end
        else if (cmd.write_res)
        begin
            vwe    = 1'b1;
            vwaddr = AW'(vcnt_reg - CW'(2));
            vwdata = alu_res;
        end
    end

    assign vraddr = rd_phase_reg ? AW'(vcnt_reg - CW'(2)) : AW'(vcnt_reg - CW'(1));

    iee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_vstack (
        .clk   (clk),
        .we    (vwe),
        .waddr (vwaddr),
        .wdata (vwdata),
        .raddr (vraddr),
        .rdata (vrdata)
    );

    assign owe    = cmd.push_op;
    assign owaddr = ocnt_reg[AW-1:0];
    assign oraddr = AW'(ocnt_reg - CW'(1));

    iee_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_ostack (
        .clk   (clk),
        .we    (owe),
        .waddr (owaddr),
        .wdata (cur_op),
        .raddr (oraddr),
        .rdata (ordata)
    );

    iee_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.alu_start),
        .op       (top_op),
        .lhs      (vrdata),
        .rhs      (rhs_reg),
        .done     (alu_done),
        .res      (alu_res),
        .div_zero (alu_dz)
    );

    always_comb
    begin
        vcnt_next = vcnt_reg;
        ocnt_next = ocnt_reg;
        err_next  = err_reg;
        if (cmd.push_val)
        begin
            vcnt_next = vcnt_reg + CW'(1);
        end
        if (cmd.write_res)
        begin
            vcnt_next = vcnt_reg - CW'(1);
            if (alu_dz && err_reg == ST_OK)
            begin
                err_next = ST_DIVZERO;
            end
        end
        if (cmd.push_op)
        begin
            ocnt_next = ocnt_reg + CW'(1);
        end
        if (cmd.pop_op)
        begin
            ocnt_next = ocnt_reg - CW'(1);
        end
        if (err_reg == ST_OK)
        begin
            if (cmd.flag_ovf)
            begin
                err_next = ST_OVERFLOW;
            end
            else if (cmd.flag_mal)
            begin
                err_next = ST_MALFORMED;
            end
            else if (cmd.flag_bad)
            begin
                err_next = ST_BADCHAR;
            end
        end
        if (cmd.clear)
        begin
            vcnt_next = '0;
            ocnt_next = '0;
            err_next  = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg     <= '0;
            ocnt_reg     <= '0;
            err_reg      <= ST_OK;
            rd_phase_reg <= 1'b0;
        end
        else
        begin
            vcnt_reg     <= vcnt_next;
            ocnt_reg     <= ocnt_next;
            err_reg      <= err_next;
            rd_phase_reg <= cmd.rd_vals;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            char_reg <= char_code;
            last_reg <= last;
        end
        // first read cycle returns top-of-stack: keep as rhs
        if (rd_phase_reg)
        begin
            rhs_reg <= vrdata;
        end
        if (cmd.finish)
        begin
            value_reg  <= (vcnt_reg == '0) ? 32'd0 : vrdata;
            status_reg <= (err_reg == ST_OK && vcnt_reg != CW'(1)) ? ST_MALFORMED : err_reg;
        end
    end

    assign sts.is_digit = is_digit;
    assign sts.is_op    = is_op;
    assign sts.last     = last_reg;
    assign sts.op_empty = (ocnt_reg == '0);
    assign sts.op_full  = (ocnt_reg >= CW'(STACK_DEPTH));
    assign sts.val_full = (vcnt_reg >= CW'(STACK_DEPTH));
    assign sts.val_lt2  = (vcnt_reg < CW'(2));
    assign sts.top_ge   = ordata[1] || !cur_op[1];
    assign sts.alu_done = alu_done;

    assign value  = value_reg;
    assign status = status_reg;
endmodule

>>> rtl/iee_ctrl.sv
module iee_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output iee_pkg::iee_cmd_t cmd,
    input  iee_pkg::iee_sts_t sts
);
    import iee_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_OPCHK  = 10'b0000000100,
        S_RDA    = 10'b0000001000,
        S_RDB    = 10'b0000010000,
        S_ALU    = 10'b0000100000,
        S_WAIT   = 10'b0001000000,
        S_PUSHOP = 10'b0010000000,
        S_FINRD  = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;
    logic   ovalid_reg, ovalid_next;

    // flush mode: reduce until empty at end of expression
    always_comb
    begin
        state_next  = state_reg;
        flush_next  = flush_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_char = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                flush_next = 1'b0;
                if (sts.is_digit)
                begin
                    if (sts.val_full)
                    begin
                        cmd.flag_ovf = 1'b1;
                    end
                    else
                    begin
                        cmd.push_val = 1'b1;
                    end
                    state_next = S_FINRD;
                end
                else if (sts.is_op)
                begin
                    state_next = S_OPCHK;
                end
                else
                begin
                    cmd.flag_bad = 1'b1;
                    state_next   = S_FINRD;
                end
            end
            S_OPCHK:
            begin
                // operator ram data valid here
                if (!sts.op_empty && (flush_reg || sts.top_ge))
                begin
                    if (sts.val_lt2)
                    begin
                        cmd.flag_mal = 1'b1;
                        cmd.pop_op   = 1'b1;
                        state_next   = S_WAIT;
                    end
                    else
                    begin
                        cmd.rd_vals = 1'b1;
                        state_next  = S_RDA;
                    end
                end
                else if (flush_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PUSHOP;
                end
            end
            S_RDA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.alu_start = 1'b1;
                state_next    = S_ALU;
            end
            S_ALU:
            begin
                if (sts.alu_done)
                begin
                    cmd.write_res = 1'b1;
                    cmd.pop_op    = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_OPCHK;
            end
            S_PUSHOP:
            begin
                if (sts.op_full)
                begin
                    cmd.flag_ovf = 1'b1;
                end
                else
                begin
                    cmd.push_op = 1'b1;
                end
                state_next = S_FINRD;
            end
            S_FINRD:
            begin
                if (sts.last)
                begin
                    flush_next = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg)
                begin
                    cmd.finish  = 1'b1;
                    cmd.clear   = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            flush_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            flush_reg  <= flush_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
endmodule

>>> sim/infix_expression_evaluator_test.sv
`timescale 1ns / 1ps

module infix_expression_evaluator_test;
    import iee_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold;
    } char_item_t;

    typedef struct {
        logic [31:0] value;
        status_t     status;
    } eval_result_t;

    logic clk;
    logic rst_n;

    iee_in_if  in_ch ();
    iee_out_if out_ch ();

    infix_expression_evaluator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    char_item_t   char_queue[$];
    eval_result_t result_queue[$];

    logic [31:0] vstk[STACK_DEPTH_DEF];
    op_t         ostk[STACK_DEPTH_DEF];
    int          vcnt;
    int          ocnt;
    status_t     sticky;

    int  fail_count;
    int  accepted_count;
    bit  in_fired;
    int  burst_left;
    int  gap_left;
    int  rcv_mode;
    int  rcv_phase;
    int  long_stall;
    bit  stall_done;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // evaluator state model
    function automatic void note_error(status_t code);
        if (sticky == ST_OK)
            sticky = code;
    endfunction

    function automatic int op_rank(op_t op);
        return (op == OP_MUL || op == OP_DIV) ? 2 : 1;
    endfunction

    function automatic logic [31:0] combine(logic [31:0] a, logic [31:0] b, op_t op);
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            default:
            begin
                if (b == 32'd0)
                begin
                    note_error(ST_DIVZERO);
                    return 32'd0;
                end
                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                    return a;
                return $signed(a) / $signed(b);
            end
        endcase
    endfunction

    function automatic void reduce_top();
        op_t op;
        op = ostk[ocnt - 1];
        ocnt--;
        if (vcnt < 2)
        begin
            note_error(ST_MALFORMED);
            return;
        end
        vstk[vcnt - 2] = combine(vstk[vcnt - 2], vstk[vcnt - 1], op);
        vcnt--;
    endfunction

    function automatic void eval_char(logic [7:0] ch, logic last);
        op_t          op;
        bit           is_op;
        eval_result_t res;
        is_op = 1'b1;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            is_op = 1'b0;
            if (vcnt >= STACK_DEPTH_DEF)
                note_error(ST_OVERFLOW);
            else
            begin
                vstk[vcnt] = 32'(ch - CH_ZERO);
                vcnt++;
            end
        end
        else if (ch == CH_PLUS)
            op = OP_ADD;
        else if (ch == CH_MINUS)
            op = OP_SUB;
        else if (ch == CH_MUL)
            op = OP_MUL;
        else if (ch == CH_DIV)
            op = OP_DIV;
        else
        begin
            is_op = 1'b0;
            note_error(ST_BADCHAR);
        end
        if (is_op)
        begin
            while (ocnt > 0 && op_rank(ostk[ocnt - 1]) >= op_rank(op))
                reduce_top();
            if (ocnt >= STACK_DEPTH_DEF)
                note_error(ST_OVERFLOW);
            else
            begin
                ostk[ocnt] = op;
                ocnt++;
            end
        end
        if (!last)
            return;
        while (ocnt > 0)
            reduce_top();
        res.value = 32'd0;
        if (vcnt == 0)
            note_error(ST_MALFORMED);
        else
        begin
            res.value = vstk[vcnt - 1];
            if (vcnt != 1)
                note_error(ST_MALFORMED);
        end
        res.status = sticky;
        result_queue.push_back(res);
        vcnt = 0;
        ocnt = 0;
        sticky = ST_OK;
    endfunction

    task automatic add_char(logic [7:0] ch, logic last);
        char_item_t it;
        it.ch = ch;
        it.last = last;
        it.hold = 1'b0;
        char_queue.push_back(it);
    endtask

    task automatic add_expr(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic add_random_expr();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 17) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                add_char(pick_digit(), i == n - 1 ? 1'b0 : 1'b0);
                if (i == n - 1)
                    char_queue[$].last = 1'b1;
                else
                    add_char(pick_op(), 1'b0);
            end
        end
        else if (kind < 85)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_char(8'($urandom_range(0, 255)), i == n - 1);
        end
        else if (kind < 92)
        begin
            n = $urandom_range(15, 19);
            for (int i = 0; i < n; i++)
                add_char(pick_digit(), i == n - 1);
        end
        else
        begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                add_char($urandom_range(0, 1) ? pick_digit() : pick_op(), i == n - 1);
        end
    endtask

    // input side
    always @(posedge clk)
    begin
        in_fired <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            eval_char(in_ch.char_code, in_ch.last);
            accepted_count <= accepted_count + 1;
        end
    end

    always @(negedge clk)
    begin
        char_item_t it;
        if (rst_n && (!in_ch.valid || in_fired))
        begin
            if (gap_left > 0)
            begin
                in_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (char_queue.size() == 0)
                in_ch.valid <= 1'b0;
            else if (char_queue[0].hold)
            begin
                in_ch.valid <= 1'b0;
                if (result_queue.size() == 0)
                    void'(char_queue.pop_front());
            end
            else
            begin
                it = char_queue.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.char_code <= it.ch;
                in_ch.last <= it.last;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // output side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rcv_phase <= rcv_phase + 1;
            if (rcv_phase % 128 == 0)
                rcv_mode <= $urandom_range(0, 2);
            if (long_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                long_stall <= long_stall - 1;
            end
            else if (!stall_done && accepted_count >= 600)
            begin
                out_ch.ready <= 1'b0;
                long_stall <= 3000;
                stall_done <= 1'b1;
            end
            else if (rcv_mode == 0)
                out_ch.ready <= 1'b1;
            else if (rcv_mode == 1)
                out_ch.ready <= (rcv_phase % 16) < 5;
            else
                out_ch.ready <= $urandom_range(0, 2) != 0;
        end
    end

    always @(posedge clk)
    begin
        eval_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (result_queue.size() == 0)
            begin
                $error("result transfer with none expected: value %0d status %0d",
                       out_ch.value, out_ch.status);
                fail_count++;
            end
            else
            begin
                want = result_queue.pop_front();
                if (out_ch.value !== want.value)
                begin
                    $error("value mismatch: expected %0d actual %0d",
                           $signed(want.value), out_ch.value);
                    fail_count++;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status mismatch: expected %0d actual %0d",
                           want.status, out_ch.status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        char_item_t pause;
        int tail;
        bit pause_added;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.char_code = 8'd0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        vcnt = 0;
        ocnt = 0;
        sticky = ST_OK;
        fail_count = 0;
        accepted_count = 0;
        burst_left = 0;
        gap_left = 0;
        rcv_mode = 0;
        rcv_phase = 0;
        long_stall = 0;
        stall_done = 1'b0;
        pause_added = 1'b0;
        pause.ch = 8'd0;
        pause.last = 1'b0;
        pause.hold = 1'b1;

        add_expr("9");
        add_expr("0*0");
        add_expr("1+2*3");
        add_expr("2+3*4-5/2");
        add_expr("8-9");
        add_expr("0-7/2");
        add_expr("1-2-3");
        add_expr("8/2/2");
        add_expr("5/0+1");
        add_expr("2*8*8*8*8*8*8*8*8*8*8/1");
        add_expr("0-2*8*8*8*8*8*8*8*8*8*8/9");
        add_expr("9*9*9*9*9*9*9*9*9*9*9*9");
        add_expr("12345678901234567");
        add_expr("12");
        add_expr("+");
        add_expr("3*");
        add_expr("a");
        add_expr("3+a4");
        add_expr("9/0*x");
        add_char(8'hFF, 1'b0);
        add_char(8'h00, 1'b1);
        while (char_queue.size() < 1900)
        begin
            if (!pause_added && char_queue.size() >= 1200)
            begin
                char_queue.push_back(pause);
                pause_added = 1'b1;
            end
            add_random_expr();
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (char_queue.size() == 0);
        @(posedge clk);
        while (in_ch.valid)
            @(posedge clk);
        while (result_queue.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 200)
        begin
            @(posedge clk);
            tail++;
        end
        if (fail_count == 0)
            $display("infix_expression_evaluator verification clean");
        else
            $display("infix_expression_evaluator verification failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("infix_expression_evaluator verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/iee_pkg.sv
rtl/iee_if.sv
rtl/iee_ram.sv
rtl/iee_alu.sv
rtl/iee_datapath.sv
rtl/iee_ctrl.sv
rtl/infix_expression_evaluator.sv
sim/infix_expression_evaluator_test.sv
